### src/csca_pkg.sv
// Shared constants for the cover-scale center-crop address block.
`timescale 1ns / 1ps
package csca_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int COORD_W    = 12;
    localparam int OFFSET_W   = 26;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_VALID   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd4;

    localparam logic [CFG_DATA_W-1:0] SCREEN_WIDTH_RST  = 13'd1024;
    localparam logic [CFG_DATA_W-1:0] SCREEN_HEIGHT_RST = 13'd768;

endpackage

### src/csca_setup.sv
// Configuration registers and the serial computation of draw size and crop.
`timescale 1ns / 1ps
module csca_setup #(
    parameter int MAX_DIM = 4096,
    parameter int DW      = 13,
    parameter int WW      = 26
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [csca_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [csca_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               pipe_idle,
    output logic                               setup_done,
    output logic                               fallback,
    output logic [DW-1:0]                      srcw,
    output logic [DW-1:0]                      srch,
    output logic [DW-1:0]                      scrw,
    output logic [DW-1:0]                      scrh,
    output logic [WW-1:0]                      draw_w,
    output logic [WW-1:0]                      draw_h,
    output logic [WW-1:0]                      crop_x,
    output logic [WW-1:0]                      crop_y
);

    localparam logic [2:0] ST_CLAMP = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_FIN   = 3'd3;
    localparam logic [2:0] ST_RUN   = 3'd4;
    localparam int CNT_W = $clog2(WW + 1);
    localparam int XW = (DW > csca_pkg::CFG_DATA_W) ? DW : csca_pkg::CFG_DATA_W;
    localparam logic [XW-1:0] MAX_X = XW'(MAX_DIM);

    logic [csca_pkg::CFG_DATA_W-1:0] src_w_cfg_reg, src_h_cfg_reg;
    logic [csca_pkg::CFG_DATA_W-1:0] scr_w_cfg_reg, scr_h_cfg_reg;
    logic                            valid_cfg_reg;
    logic [2:0]                      state_reg;
    logic [DW-1:0]                   srcw_reg, srch_reg, scrw_reg, scrh_reg;
    logic                            fb_reg, wide_reg;
    logic [WW-1:0]                   num_reg;
    logic [DW-1:0]                   den_reg, rem_reg;
    logic [CNT_W-1:0]                cnt_reg;
    logic [WW-1:0]                   draw_w_reg, draw_h_reg, crop_x_reg, crop_y_reg;
    logic [WW-1:0]                   sw, sh;
    logic [DW:0]                     r2;
    logic                            r_ge;

    function automatic logic [DW-1:0] clamp_dim(input logic [csca_pkg::CFG_DATA_W-1:0] v,
                                                input logic lo_one);
        logic [XW-1:0] ve;
        begin
            ve = XW'(v);
            if (ve > MAX_X)
            begin
                clamp_dim = DW'(MAX_DIM);
            end
            else if (lo_one && ve == '0)
            begin
                clamp_dim = DW'(1);
            end
            else
            begin
                clamp_dim = DW'(ve);
            end
        end
    endfunction

    assign sw   = WW'(srcw_reg) * WW'(scrh_reg);
    assign sh   = WW'(srch_reg) * WW'(scrw_reg);
    assign r2   = {rem_reg, num_reg[WW-1]};
    assign r_ge = r2 >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_cfg_reg <= 1'b0;
            src_w_cfg_reg <= '0;
            src_h_cfg_reg <= '0;
            scr_w_cfg_reg <= csca_pkg::SCREEN_WIDTH_RST;
            scr_h_cfg_reg <= csca_pkg::SCREEN_HEIGHT_RST;
            state_reg     <= ST_CLAMP;
            fb_reg        <= 1'b1;
            wide_reg      <= 1'b0;
            cnt_reg       <= '0;
        end
        else if (cfg_valid && pipe_idle)
        begin
            case (cfg_index)
                csca_pkg::CFG_IMAGE_VALID:   valid_cfg_reg <= cfg_data[0];
                csca_pkg::CFG_SOURCE_WIDTH:  src_w_cfg_reg <= cfg_data;
                csca_pkg::CFG_SOURCE_HEIGHT: src_h_cfg_reg <= cfg_data;
                csca_pkg::CFG_SCREEN_WIDTH:  scr_w_cfg_reg <= cfg_data;
                csca_pkg::CFG_SCREEN_HEIGHT: scr_h_cfg_reg <= cfg_data;
                default: ;
            endcase
            state_reg <= ST_CLAMP;
        end
        else
        begin
            case (state_reg)
                ST_CLAMP:
                begin
                    fb_reg    <= !valid_cfg_reg || src_w_cfg_reg == '0 || src_h_cfg_reg == '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    wide_reg  <= sw >= sh;
                    cnt_reg   <= '0;
                    state_reg <= fb_reg ? ST_RUN : ST_DIV;
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(WW - 1))
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    state_reg <= ST_RUN;
                end
                ST_RUN:  ;
                default: state_reg <= ST_CLAMP;
            endcase
        end
    end

    // Datapath registers of the setup sequencer.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_CLAMP:
            begin
                srcw_reg <= clamp_dim(src_w_cfg_reg, 1'b0);
                srch_reg <= clamp_dim(src_h_cfg_reg, 1'b0);
                scrw_reg <= clamp_dim(scr_w_cfg_reg, 1'b1);
                scrh_reg <= clamp_dim(scr_h_cfg_reg, 1'b1);
            end
            ST_MUL:
            begin
                num_reg <= (sw >= sh) ? sw : sh;
                den_reg <= (sw >= sh) ? srch_reg : srcw_reg;
                rem_reg <= '0;
            end
            ST_DIV:
            begin
                rem_reg <= r_ge ? DW'(r2 - {1'b0, den_reg}) : DW'(r2);
                num_reg <= {num_reg[WW-2:0], r_ge};
            end
            ST_FIN:
            begin
                if (wide_reg)
                begin
                    draw_w_reg <= num_reg;
                    draw_h_reg <= WW'(scrh_reg);
                    crop_x_reg <= (num_reg - WW'(scrw_reg)) >> 1;
                    crop_y_reg <= '0;
                end
                else
                begin
                    draw_w_reg <= WW'(scrw_reg);
                    draw_h_reg <= num_reg;
                    crop_x_reg <= '0;
                    crop_y_reg <= (num_reg - WW'(scrh_reg)) >> 1;
                end
            end
            default: ;
        endcase
    end

    // A register write is taken only once no pixel is left in the pipeline.
    assign cfg_ready  = pipe_idle;
    assign setup_done = state_reg == ST_RUN;
    assign fallback   = fb_reg;
    assign srcw       = srcw_reg;
    assign srch       = srch_reg;
    assign scrw       = scrw_reg;
    assign scrh       = scrh_reg;
    assign draw_w     = draw_w_reg;
    assign draw_h     = draw_h_reg;
    assign crop_x     = crop_x_reg;
    assign crop_y     = crop_y_reg;

endmodule

### src/cover_scale_center_crop_addr_top.sv
// A pixel passes stage 0, stage 1, the quotient stages, the row times width stage and the output
// register. Throughput: one pixel per cycle while no register write is offered; a stalled output
// freezes the whole pipeline. The quotient pipeline computes one column bit and one row bit per
// stage. After reset and each register transfer, a serial setup (clamp, multiply, divide, finish;
// no divide or finish on fallback) computes draw size and crop; in_ready stays low meanwhile.
// A register transfer waits for an empty pipeline; reset clears valid bits, loads config defaults.
`timescale 1ns / 1ps
module cover_scale_center_crop_addr_top #(
    parameter int MAX_DIM = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [csca_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [csca_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [csca_pkg::COORD_W-1:0]        dest_x,
    input  logic [csca_pkg::COORD_W-1:0]        dest_y,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                use_fallback,
    output logic [csca_pkg::COORD_W-1:0]        source_col,
    output logic [csca_pkg::COORD_W-1:0]        source_row,
    output logic [csca_pkg::OFFSET_W-1:0]       byte_offset
);

    // Size width, draw width, quotient width and numerator width.
    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int WW = 2 * DW;
    localparam int QW = $clog2(MAX_DIM);
    localparam int NW = WW + DW;
    localparam int XW = (DW > csca_pkg::COORD_W) ? DW : csca_pkg::COORD_W;
    localparam int CW = (QW > csca_pkg::COORD_W) ? QW : csca_pkg::COORD_W;
    localparam int BW = QW + DW + 2;
    localparam int OW = (BW > csca_pkg::OFFSET_W) ? BW : csca_pkg::OFFSET_W;

    logic            setup_done, fallback, pipe_idle;
    logic [DW-1:0]   srcw, srch, scrw, scrh;
    logic [WW-1:0]   draw_w, draw_h, crop_x, crop_y;

    // Derived scaling values are held static while pixels flow.
    csca_setup #(
        .MAX_DIM (MAX_DIM),
        .DW      (DW),
        .WW      (WW)
    ) u_setup (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pipe_idle  (pipe_idle),
        .setup_done (setup_done),
        .fallback   (fallback),
        .srcw       (srcw),
        .srch       (srch),
        .scrw       (scrw),
        .scrh       (scrh),
        .draw_w     (draw_w),
        .draw_h     (draw_h),
        .crop_x     (crop_x),
        .crop_y     (crop_y)
    );

    // The whole pipeline advances together whenever the output stage can move.
    // No pixel is taken while a register write is offered, so the write can go
    // through as soon as the pipeline has emptied.
    logic adv;
    assign adv      = !out_valid || out_ready;
    assign in_ready = setup_done && adv && !cfg_valid;

    // Stage 0: clamp the coordinate to the screen and add the crop offset.
    logic            v0_reg;
    logic [WW-1:0]   ax0_reg, ay0_reg;
    logic [DW-1:0]   dx_c, dy_c;

    always_comb
    begin
        if (XW'(dest_x) >= XW'(scrw))
        begin
            dx_c = scrw - 1'b1;
        end
        else
        begin
            dx_c = DW'(dest_x);
        end
        if (XW'(dest_y) >= XW'(scrh))
        begin
            dy_c = scrh - 1'b1;
        end
        else
        begin
            dy_c = DW'(dest_y);
        end
    end

    // Stage 1: scale the shifted coordinate by the source size.
    logic            v1_reg;
    logic [NW-1:0]   nx1_reg, ny1_reg;

    // Quotient stages: stage k resolves bit QW-1-k of column and row.
    logic            vd_reg [QW];
    logic [NW-1:0]   rx_reg [QW];
    logic [NW-1:0]   ry_reg [QW];
    logic [QW-1:0]   qx_reg [QW];
    logic [QW-1:0]   qy_reg [QW];
    logic [NW-1:0]   rx_next [QW];
    logic [NW-1:0]   ry_next [QW];
    logic [QW-1:0]   qx_next [QW];
    logic [QW-1:0]   qy_next [QW];

    always_comb
    begin
        for (int k = 0; k < QW; k++)
        begin
            logic [NW-1:0] rin_x, rin_y, dsx, dsy;
            logic [QW-1:0] qin_x, qin_y;
            rin_x = (k == 0) ? nx1_reg : rx_reg[(k == 0) ? 0 : k - 1];
            rin_y = (k == 0) ? ny1_reg : ry_reg[(k == 0) ? 0 : k - 1];
            qin_x = (k == 0) ? '0 : qx_reg[(k == 0) ? 0 : k - 1];
            qin_y = (k == 0) ? '0 : qy_reg[(k == 0) ? 0 : k - 1];
            dsx   = NW'(draw_w) << (QW - 1 - k);
            dsy   = NW'(draw_h) << (QW - 1 - k);
            if (rin_x >= dsx)
            begin
                rx_next[k] = rin_x - dsx;
                qx_next[k] = qin_x | (QW'(1) << (QW - 1 - k));
            end
            else
            begin
                rx_next[k] = rin_x;
                qx_next[k] = qin_x;
            end
            if (rin_y >= dsy)
            begin
                ry_next[k] = rin_y - dsy;
                qy_next[k] = qin_y | (QW'(1) << (QW - 1 - k));
            end
            else
            begin
                ry_next[k] = rin_y;
                qy_next[k] = qin_y;
            end
        end
    end

    // Row times width stage, then the output register.
    logic                 vm_reg;
    logic [QW+DW-1:0]     prod_reg;
    logic [QW-1:0]        colm_reg, rowm_reg;
    logic                 vo_reg;
    logic [OW-1:0]        lin_sum, off_sum;
    logic [CW-1:0]        col_ext, row_ext;
    logic [csca_pkg::COORD_W-1:0]  col_reg, row_reg;
    logic [csca_pkg::OFFSET_W-1:0] off_reg;
    logic                          fb_out_reg;
    logic                          any_vd;

    assign lin_sum = OW'(prod_reg) + OW'(colm_reg);
    assign off_sum = lin_sum + (lin_sum << 1);
    assign col_ext = CW'(colm_reg);
    assign row_ext = CW'(rowm_reg);

    // The pipeline is empty when no stage holds a valid pixel.
    always_comb
    begin
        any_vd = 1'b0;
        for (int k = 0; k < QW; k++)
        begin
            any_vd = any_vd | vd_reg[k];
        end
    end

    assign pipe_idle = !(v0_reg || v1_reg || any_vd || vm_reg || vo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            vm_reg <= 1'b0;
            vo_reg <= 1'b0;
            for (int k = 0; k < QW; k++)
            begin
                vd_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v0_reg <= in_valid && in_ready;
            v1_reg <= v0_reg;
            for (int k = 0; k < QW; k++)
            begin
                vd_reg[k] <= (k == 0) ? v1_reg : vd_reg[(k == 0) ? 0 : k - 1];
            end
            vm_reg <= vd_reg[QW-1];
            vo_reg <= vm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax0_reg <= WW'(dx_c) + crop_x;
            ay0_reg <= WW'(dy_c) + crop_y;
            nx1_reg <= NW'(ax0_reg) * NW'(srcw);
            ny1_reg <= NW'(ay0_reg) * NW'(srch);
            for (int k = 0; k < QW; k++)
            begin
                rx_reg[k] <= rx_next[k];
                ry_reg[k] <= ry_next[k];
                qx_reg[k] <= qx_next[k];
                qy_reg[k] <= qy_next[k];
            end
            prod_reg <= (QW + DW)'(qy_reg[QW-1]) * (QW + DW)'(srcw);
            colm_reg <= qx_reg[QW-1];
            rowm_reg <= qy_reg[QW-1];
            // Fallback forces every address field to zero.
            fb_out_reg <= fallback;
            col_reg    <= fallback ? '0 : col_ext[csca_pkg::COORD_W-1:0];
            row_reg    <= fallback ? '0 : row_ext[csca_pkg::COORD_W-1:0];
            off_reg    <= fallback ? '0 : off_sum[csca_pkg::OFFSET_W-1:0];
        end
    end

    assign out_valid    = vo_reg;
    assign use_fallback = fb_out_reg;
    assign source_col   = col_reg;
    assign source_row   = row_reg;
    assign byte_offset  = off_reg;

endmodule

### tb/tb_cover_scale_center_crop_addr_top.sv
// Self-checking testbench for the cover-scale center-crop address block.
`timescale 1ns / 1ps
module tb_cover_scale_center_crop_addr_top;

    localparam int CFG_IDX_W  = csca_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = csca_pkg::CFG_DATA_W;
    localparam int COORD_W    = csca_pkg::COORD_W;
    localparam int OFFSET_W   = csca_pkg::OFFSET_W;

    // A register index past the end of the register list; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd5;
    localparam int MAX_DIM       = 4096;
    localparam int PIXEL_BYTES   = 3;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 400;
    localparam int HOLD_CYCLES   = 300;
    localparam int DIR_ROWS      = 30;

    typedef enum logic { ROW_CFG, ROW_PIX } row_kind_t;

    // One source pixel address, as the block reports it.
    typedef struct packed {
        logic                fallback;
        logic [COORD_W-1:0]  col;
        logic [COORD_W-1:0]  row;
        logic [OFFSET_W-1:0] offset;
    } src_pixel_t;

    // One row of the directed table: either a register write or a pixel transfer.
    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [COORD_W-1:0]    x;
        logic [COORD_W-1:0]    y;
        bit                    typed;
        src_pixel_t            want;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [COORD_W-1:0]    dest_x;
    logic [COORD_W-1:0]    dest_y;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  use_fallback;
    logic [COORD_W-1:0]    source_col;
    logic [COORD_W-1:0]    source_row;
    logic [OFFSET_W-1:0]   byte_offset;

    // Shadow copy of the configuration registers, updated on each register transfer.
    logic                  sh_image_valid;
    logic [CFG_DATA_W-1:0] sh_src_w;
    logic [CFG_DATA_W-1:0] sh_src_h;
    logic [CFG_DATA_W-1:0] sh_scr_w;
    logic [CFG_DATA_W-1:0] sh_scr_h;

    src_pixel_t pending_pixels[$];
    int         mismatches  = 0;
    int         cycle_count = 0;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         hold_requests;
    int         hold_served = 0;
    int         hold_left   = 0;

    cover_scale_center_crop_addr_top #(
        .MAX_DIM(MAX_DIM)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .dest_x       (dest_x),
        .dest_y       (dest_y),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .use_fallback (use_fallback),
        .source_col   (source_col),
        .source_row   (source_row),
        .byte_offset  (byte_offset)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Sizes above the largest supported dimension saturate; a zero screen size counts as one.
    function automatic longint unsigned clamp_dim(input longint unsigned v,
                                                  input longint unsigned lo);
        if (v > MAX_DIM)
            return MAX_DIM;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // Works out which source pixel covers screen pixel (x, y) under the shadow configuration.
    function automatic src_pixel_t covering_pixel(input logic [COORD_W-1:0] x,
                                                  input logic [COORD_W-1:0] y);
        longint unsigned srcw, srch, scrw, scrh, dx, dy;
        longint unsigned fill_w, fill_h, draw_w, draw_h, crop_x, crop_y, col, row;
        src_pixel_t      p;
        srcw = clamp_dim(sh_src_w, 0);
        srch = clamp_dim(sh_src_h, 0);
        scrw = clamp_dim(sh_scr_w, 1);
        scrh = clamp_dim(sh_scr_h, 1);
        dx   = x;
        dy   = y;
        p    = '0;
        if (!sh_image_valid || srcw == 0 || srch == 0)
        begin
            p.fallback = 1'b1;
            return p;
        end
        if (dx >= scrw)
            dx = scrw - 1;
        if (dy >= scrh)
            dy = scrh - 1;
        // Compare the aspect ratios by cross multiplication; the wider side overflows.
        fill_w = srcw * scrh;
        fill_h = srch * scrw;
        if (fill_w >= fill_h)
        begin
            draw_w = fill_w / srch;
            draw_h = scrh;
        end
        else
        begin
            draw_w = scrw;
            draw_h = fill_h / srcw;
        end
        crop_x   = (draw_w - scrw) / 2;
        crop_y   = (draw_h - scrh) / 2;
        col      = ((dx + crop_x) * srcw) / draw_w;
        row      = ((dy + crop_y) * srch) / draw_h;
        p.col    = col[COORD_W-1:0];
        p.row    = row[COORD_W-1:0];
        p.offset = OFFSET_W'((row * srcw + col) * PIXEL_BYTES);
        return p;
    endfunction

    // Cycle counter and watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: checks every result transfer against the oldest expectation, then picks
    // the next value of out_ready. A long hold-off requested by the stimulus is counted
    // down here so that the sender keeps offering items while the pipeline backs up.
    always @(posedge clk)
    begin
        src_pixel_t got, want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{use_fallback, source_col, source_row, byte_offset};
            if (pending_pixels.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("Unexpected result transfer: fb=%0d col=%0d row=%0d off=%0d",
                             got.fallback, got.col, got.row, got.offset);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (got !== want)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                    begin
                        $display("Mismatch at cycle %0d: expected fb=%0d col=%0d row=%0d off=%0d",
                                 cycle_count, want.fallback, want.col, want.row, want.offset);
                        $display("    got fb=%0d col=%0d row=%0d off=%0d",
                                 got.fallback, got.col, got.row, got.offset);
                    end
                end
            end
        end
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offers one pixel and waits for its transfer. The valid is left high so that the
    // caller may present the next pixel in the same step or lower it for a gap.
    task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        in_valid <= 1'b1;
        dest_x   <= x;
        dest_y   <= y;
        do
            @(posedge clk);
        while (!in_ready);
        pending_pixels.push_back(covering_pixel(x, y));
    endtask

    // Random gaps on the pixel input, at the current sender idle rate.
    task automatic sender_gap();
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Stops offering pixels until every expected result has arrived, then lets the
    // pipeline settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register writes happen only with the block idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            csca_pkg::CFG_IMAGE_VALID:   sh_image_valid = data[0];
            csca_pkg::CFG_SOURCE_WIDTH:  sh_src_w = data;
            csca_pkg::CFG_SOURCE_HEIGHT: sh_src_h = data;
            csca_pkg::CFG_SCREEN_WIDTH:  sh_scr_w = data;
            csca_pkg::CFG_SCREEN_HEIGHT: sh_scr_h = data;
            default:                     ;
        endcase
    endtask

    // Picks a size that favors the interesting corners: zero, one, the largest supported
    // size, values above it that must saturate, and the full 13-bit range.
    function automatic logic [CFG_DATA_W-1:0] pick_size();
        case ($urandom_range(9))
            0: return 13'd0;
            1: return 13'd1;
            2: return CFG_DATA_W'(MAX_DIM);
            3: return 13'h1FFF;
            4: return CFG_DATA_W'($urandom_range(8191));
            5: return CFG_DATA_W'($urandom_range(16, 1));
            default: return CFG_DATA_W'($urandom_range(2048, 2));
        endcase
    endfunction

    // Mostly coordinates on screen, with some past its edge and some at the field extremes.
    function automatic logic [COORD_W-1:0] pick_coord(input logic [CFG_DATA_W-1:0] extent);
        int lim;
        lim = (extent == 0) ? 1 : ((extent > MAX_DIM) ? MAX_DIM : extent);
        case ($urandom_range(7))
            0: return COORD_W'($urandom_range(4095));
            1: return 12'hFFF;
            2: return 12'h000;
            3: return COORD_W'(lim - 1);
            default: return COORD_W'($urandom_range(lim - 1));
        endcase
    endfunction

    // Directed table. Rows with typed results can be read straight off the behavior:
    // fallback, after reset or with no usable image, and an image exactly the size of the screen, where
    // every screen pixel maps onto itself.
    dir_row_t directed [DIR_ROWS] = '{
        '{ROW_PIX, 0, 0, 12'd0, 12'd0, 1, '{1'b1, 12'd0, 12'd0, 26'd0}},
        '{ROW_PIX, 0, 0, 12'hFFF, 12'hFFF, 1, '{1'b1, 12'd0, 12'd0, 26'd0}},
        '{ROW_CFG, csca_pkg::CFG_IMAGE_VALID, 13'd1, 0, 0, 0, '0},
        '{ROW_PIX, 0, 0, 12'd7, 12'd9, 1, '{1'b1, 12'd0, 12'd0, 26'd0}},
        '{ROW_CFG, csca_pkg::CFG_SOURCE_WIDTH, 13'd1024, 0, 0, 0, '0},
        '{ROW_CFG, csca_pkg::CFG_SOURCE_HEIGHT, 13'd768, 0, 0, 0, '0},
        '{ROW_PIX, 0, 0, 12'd0, 12'd0, 1, '{1'b0, 12'd0, 12'd0, 26'd0}},
        '{ROW_PIX, 0, 0, 12'd5, 12'd3, 1, '{1'b0, 12'd5, 12'd3, 26'd9231}},
        '{ROW_PIX, 0, 0, 12'd1023, 12'd767, 1, '{1'b0, 12'd1023, 12'd767, 26'd2359293}},
        '{ROW_PIX, 0, 0, 12'hFFF, 12'hFFF, 1, '{1'b0, 12'd1023, 12'd767, 26'd2359293}},
        // Wide source on the default landscape screen, cropped at the left and right.
        '{ROW_CFG, csca_pkg::CFG_SOURCE_WIDTH, 13'd4096, 0, 0, 0, '0},
        '{ROW_CFG, csca_pkg::CFG_SOURCE_HEIGHT, 13'd1, 0, 0, 0, '0},
        '{ROW_PIX, 0, 0, 12'd0, 12'd0, 0, '0},
        '{ROW_PIX, 0, 0, 12'd512, 12'd400, 0, '0},
        // Oversized sizes saturate, a zero screen size counts as one.
        '{ROW_CFG, csca_pkg::CFG_SOURCE_HEIGHT, 13'h1FFF, 0, 0, 0, '0},
        '{ROW_CFG, csca_pkg::CFG_SCREEN_WIDTH, 13'h1FFF, 0, 0, 0, '0},
        '{ROW_CFG, csca_pkg::CFG_SCREEN_HEIGHT, 13'd0, 0, 0, 0, '0},
        '{ROW_PIX, 0, 0, 12'hFFF, 12'hFFF, 0, '0},
        '{ROW_PIX, 0, 0, 12'd2048, 12'd1, 0, '0},
        // Tall narrow source, cropped at top and bottom.
        '{ROW_CFG, csca_pkg::CFG_SOURCE_WIDTH, 13'd1, 0, 0, 0, '0},
        '{ROW_CFG, csca_pkg::CFG_SCREEN_HEIGHT, 13'd4096, 0, 0, 0, '0},
        '{ROW_PIX, 0, 0, 12'd100, 12'd4095, 0, '0},
        '{ROW_PIX, 0, 0, 12'hAAA, 12'h555, 0, '0},
        // A write past the register list leaves everything as it was.
        '{ROW_CFG, CFG_UNUSED_IDX, 13'h1FFF, 0, 0, 0, '0},
        '{ROW_PIX, 0, 0, 12'h555, 12'hAAA, 0, '0},
        // Zero source width falls back even with a valid image.
        '{ROW_CFG, csca_pkg::CFG_SOURCE_WIDTH, 13'd0, 0, 0, 0, '0},
        '{ROW_PIX, 0, 0, 12'd12, 12'd34, 1, '{1'b1, 12'd0, 12'd0, 26'd0}},
        '{ROW_CFG, csca_pkg::CFG_IMAGE_VALID, 13'd0, 0, 0, 0, '0},
        '{ROW_CFG, csca_pkg::CFG_SOURCE_WIDTH, 13'd640, 0, 0, 0, '0},
        '{ROW_PIX, 0, 0, 12'd12, 12'd34, 1, '{1'b1, 12'd0, 12'd0, 26'd0}}
    };

    initial
    begin
        int phase;
        int burst;
        int mode_items;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        dest_x         = '0;
        dest_y         = '0;
        send_idle_pct  = 37;
        recv_idle_pct  = 73;
        hold_requests  = 0;
        sh_image_valid = 1'b0;
        sh_src_w       = '0;
        sh_src_h       = '0;
        sh_scr_w       = csca_pkg::SCREEN_WIDTH_RST;
        sh_scr_h       = csca_pkg::SCREEN_HEIGHT_RST;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Typed rows replace the predicted result with the one in the table.
        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_CFG)
                write_reg(directed[i].idx, directed[i].data);
            else
            begin
                sender_gap();
                send_pixel(directed[i].x, directed[i].y);
                if (directed[i].typed)
                begin
                    void'(pending_pixels.pop_back());
                    pending_pixels.push_back(directed[i].want);
                end
            end
        end

        // Random part in three idling phases: sender idles less than the receiver, then
        // the other way round, then neither idles.
        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 37 : ((phase == 1) ? 73 : 0);
            recv_idle_pct = (phase == 0) ? 73 : ((phase == 1) ? 37 : 0);
            mode_items = 0;
            while (mode_items < RANDOM_ITEMS / 3)
            begin
                // New random configuration; the valid bit is mostly set so that the
                // scaling path sees most of the traffic.
                write_reg(csca_pkg::CFG_IMAGE_VALID,
                          ($urandom_range(9) != 0) ? 13'd1 : 13'd0);
                write_reg(csca_pkg::CFG_SOURCE_WIDTH, pick_size());
                write_reg(csca_pkg::CFG_SOURCE_HEIGHT, pick_size());
                write_reg(csca_pkg::CFG_SCREEN_WIDTH, pick_size());
                write_reg(csca_pkg::CFG_SCREEN_HEIGHT, pick_size());
                if ($urandom_range(7) == 0)
                    write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom_range(8191)));
                // The receiver holds off for a long stretch in the first burst of the
                // last phase while pixels keep coming, so the pipeline backs up.
                if (phase == 2 && mode_items == 0)
                    hold_requests = hold_requests + 1;
                for (burst = $urandom_range(40, 15); burst > 0; burst--)
                begin
                    sender_gap();
                    send_pixel(pick_coord(sh_scr_w), pick_coord(sh_scr_h));
                    mode_items++;
                    // Once in a while in the second phase the sender pauses until every result is in.
                    if (burst == 8 && phase == 1)
                        drain_results();
                end
            end
        end

        drain_results();
        if (mismatches == 0 && pending_pixels.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
